// ===== rtl/sobel_edge_magnitude_stream_assert.svh =====
// ----------------------------------------------------------------------------
// Sobel edge magnitude assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_MAGNITUDE_STREAM_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_STREAM_ASSERT_SVH

// same-cycle implication
`define SEM_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sem assertion failed");

// next-cycle implication
`define SEM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sem assertion failed");

`endif

// ===== rtl/sem_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Sizes, register indexes, controller states and control bundles.
// ----------------------------------------------------------------------------
package sem_pkg;

   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;

   localparam int PIX_W      = 8;
   localparam int CFG_W      = 13;
   localparam int OUT_POS_W  = 12;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int CMP_W      = CFG_W + 1;
   localparam int LINE_W     = 2 * PIX_W;

   localparam int GRAD_W     = PIX_W + 3;
   localparam int PROD_W     = 2 * GRAD_W;
   localparam int ROOT_W     = 2 * PIX_W;
   localparam int ROOT_STEPS = ROOT_W / 2;
   localparam int STEP_CNT_W = $clog2(ROOT_STEPS);

   localparam int CSR_IDX_W  = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = CSR_IDX_W'(1);

   localparam logic [CFG_W-1:0] SIZE_MIN   = CFG_W'(3);
   localparam logic [CFG_W-1:0] WIDTH_MAX  = CFG_W'(MAX_WIDTH);
   localparam logic [CFG_W-1:0] HEIGHT_MAX = CFG_W'(MAX_HEIGHT);

   localparam logic [PROD_W-1:0]     ENERGY_SAT    = PROD_W'(65025);
   localparam logic [PIX_W-1:0]      MAG_MAX       = {PIX_W{1'b1}};
   localparam logic [ROOT_W-1:0]     ROOT_BIT_INIT = {2'b01, {(ROOT_W-2){1'b0}}};
   localparam logic [STEP_CNT_W-1:0] STEP_LAST     = STEP_CNT_W'(ROOT_STEPS - 1);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_LOAD   = 6'b000010,
      S_SQUARE = 6'b000100,
      S_PREP   = 6'b001000,
      S_ROOT   = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

   typedef struct packed {
      logic accept;
      logic load;
      logic square;
      logic prep;
      logic step;
      logic publish;
   } dp_cmd_type;

   typedef struct packed {
      logic emit;
      logic out_free;
   } dp_sts_type;

endpackage

// ===== rtl/sem_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write address per cycle, registered read data.
// ----------------------------------------------------------------------------
module sem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/sem_ctrl.sv =====
`timescale 1ns / 1ps
`include "sobel_edge_magnitude_stream_assert.svh"
// ----------------------------------------------------------------------------
// Sobel edge magnitude controller
// Sequences load, gradient, square, root and output steps for one beat.
// ----------------------------------------------------------------------------
module sem_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  sem_pkg::dp_sts_type sts,
   output sem_pkg::dp_cmd_type cmd
);
   import sem_pkg::*;

   state_type               state_ff, state_in;
   logic [STEP_CNT_W-1:0]   cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            state_in = sts.emit ? S_SQUARE : S_IDLE;
         end
         S_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = S_PREP;
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            cnt_in   = '0;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + STEP_CNT_W'(1);
            if (cnt_ff == STEP_LAST) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   `SEM_ASSERT_NEXT(a_accept_load, clock, reset, cmd.accept, state_ff == S_LOAD)
   `SEM_ASSERT_IMPLIES(a_publish_free, clock, reset, cmd.publish, sts.out_free)
   `SEM_ASSERT_NEXT(a_root_exit, clock, reset, state_ff == S_ROOT && cnt_ff == STEP_LAST, state_ff == S_DONE)

endmodule

// ===== rtl/sem_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude datapath
// Size registers, raster position, line buffer RAM, window, gradient,
// energy, bit-pair square root and output register.
// ----------------------------------------------------------------------------
module sem_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  sem_pkg::dp_cmd_type             cmd,
   output sem_pkg::dp_sts_type             sts,
   input  logic                            csr_we,
   input  logic [sem_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sem_pkg::CFG_W-1:0]       csr_wdata,
   input  logic [sem_pkg::PIX_W-1:0]       req_pixel,
   input  logic                            req_frame_start,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [sem_pkg::PIX_W-1:0]       rsp_magnitude,
   output logic [sem_pkg::OUT_POS_W-1:0]   rsp_out_row,
   output logic [sem_pkg::OUT_POS_W-1:0]   rsp_out_column,
   output logic                            rsp_frame_last
);
   import sem_pkg::*;

   localparam int PAD_W = GRAD_W - PIX_W;

   logic [CFG_W-1:0]      width_ff, width_in, height_ff, height_in;
   logic [CFG_W-1:0]      eff_w, eff_h;
   logic [CMP_W-1:0]      w_ext, h_ext, r_ext, c_ext;

   logic [ROW_W-1:0]      row_ff, row_in, cur_r;
   logic [COL_W-1:0]      col_ff, col_in, cur_c;

   logic [ROW_W-1:0]      cur_row_ff;
   logic [COL_W-1:0]      cur_col_ff;
   logic [PIX_W-1:0]      pix_ff;
   logic                  emit_ff, last_ff;

   logic [COL_W-1:0]      ram_addr;
   logic [LINE_W-1:0]     ram_wdata, ram_rdata;
   logic [PIX_W-1:0]      up_pix, mid_pix;

   logic [PIX_W-1:0]      win_ff [6];

   logic signed [GRAD_W-1:0] pa, pb, pp, pw0, pw1, pw2, pw3, pw5;
   logic signed [GRAD_W-1:0] gx_ff, gx_in, gy_ff, gy_in;
   logic signed [PROD_W-1:0] sq_x, sq_y;
   logic [PROD_W-1:0]        energy_ff;

   logic [ROOT_W-1:0]     x_ff, x_in, res_ff, res_in, bit_ff, bit_in;
   logic [ROOT_W:0]       trial;
   logic                  sat_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]      mag_ff;
   logic [OUT_POS_W-1:0]  out_row_ff, out_col_ff;
   logic                  out_last_ff;

   // size registers, clamped to the supported range
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata;
            CSR_IMAGE_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   assign eff_w = (width_ff < SIZE_MIN) ? SIZE_MIN :
                  (width_ff > WIDTH_MAX) ? WIDTH_MAX : width_ff;
   assign eff_h = (height_ff < SIZE_MIN) ? SIZE_MIN :
                  (height_ff > HEIGHT_MAX) ? HEIGHT_MAX : height_ff;

   // raster position of the incoming beat
   assign cur_r = req_frame_start ? '0 : row_ff;
   assign cur_c = req_frame_start ? '0 : col_ff;
   assign w_ext = CMP_W'(eff_w);
   assign h_ext = CMP_W'(eff_h);
   assign r_ext = CMP_W'(cur_r);
   assign c_ext = CMP_W'(cur_c);

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (cmd.accept) begin
         if (c_ext + CMP_W'(1) >= w_ext) begin
            col_in = '0;
            row_in = (r_ext + CMP_W'(1) >= h_ext) ? '0 : cur_r + ROW_W'(1);
         end else begin
            col_in = cur_c + COL_W'(1);
            row_in = cur_r;
         end
      end
   end

   // line buffers: upper in the high byte, middle in the low byte
   assign ram_addr  = cmd.load ? cur_col_ff : cur_c;
   assign up_pix    = ram_rdata[LINE_W-1:PIX_W];
   assign mid_pix   = ram_rdata[PIX_W-1:0];
   assign ram_wdata = {mid_pix, pix_ff};

   sem_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock (clock),
      .we    (cmd.load),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // gradients
   assign pa  = $signed({{PAD_W{1'b0}}, up_pix});
   assign pb  = $signed({{PAD_W{1'b0}}, mid_pix});
   assign pp  = $signed({{PAD_W{1'b0}}, pix_ff});
   assign pw0 = $signed({{PAD_W{1'b0}}, win_ff[0]});
   assign pw1 = $signed({{PAD_W{1'b0}}, win_ff[1]});
   assign pw2 = $signed({{PAD_W{1'b0}}, win_ff[2]});
   assign pw3 = $signed({{PAD_W{1'b0}}, win_ff[3]});
   assign pw5 = $signed({{PAD_W{1'b0}}, win_ff[5]});

   assign gx_in = (pa - pw0) + ((pb - pw1) <<< 1) + (pp - pw2);
   assign gy_in = (pw0 + (pw3 <<< 1) + pa) - (pw2 + (pw5 <<< 1) + pp);

   assign sq_x = gx_ff * gx_ff;
   assign sq_y = gy_ff * gy_ff;

   // one bit pair of the floor square root per step
   always_comb begin
      x_in   = x_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      trial  = {1'b0, res_ff} + {1'b0, bit_ff};
      if (cmd.prep) begin
         x_in   = energy_ff[ROOT_W-1:0];
         res_in = '0;
         bit_in = ROOT_BIT_INIT;
      end else if (cmd.step) begin
         if ({1'b0, x_ff} >= trial) begin
            x_in   = x_ff - trial[ROOT_W-1:0];
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_MAX;
         height_ff    <= HEIGHT_MAX;
         row_ff       <= '0;
         col_ff       <= '0;
         emit_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.accept) begin
            emit_ff <= (r_ext >= CMP_W'(2)) && (c_ext >= CMP_W'(2)) &&
                       (r_ext < h_ext) && (c_ext < w_ext);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cur_row_ff <= cur_r;
         cur_col_ff <= cur_c;
         pix_ff     <= req_pixel;
         last_ff    <= (r_ext == h_ext - CMP_W'(1)) && (c_ext == w_ext - CMP_W'(1));
      end
      if (cmd.load) begin
         gx_ff     <= gx_in;
         gy_ff     <= gy_in;
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= up_pix;
         win_ff[4] <= mid_pix;
         win_ff[5] <= pix_ff;
      end
      if (cmd.square) begin
         energy_ff <= $unsigned(sq_x) + $unsigned(sq_y);
      end
      if (cmd.prep) begin
         sat_ff <= (energy_ff >= ENERGY_SAT);
      end
      x_ff   <= x_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      if (cmd.publish) begin
         mag_ff      <= sat_ff ? MAG_MAX : res_ff[PIX_W-1:0];
         out_row_ff  <= OUT_POS_W'(cur_row_ff - ROW_W'(1));
         out_col_ff  <= OUT_POS_W'(cur_col_ff - COL_W'(1));
         out_last_ff <= last_ff;
      end
   end

   assign sts.emit     = emit_ff;
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_magnitude  = mag_ff;
   assign rsp_out_row    = out_row_ff;
   assign rsp_out_column = out_col_ff;
   assign rsp_frame_last = out_last_ff;

endmodule

// ===== rtl/sobel_edge_magnitude_stream.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude stream
// 3x3 Sobel gradient magnitude over a raster pixel stream, clipped to 255.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   pixel, frame_start
//   rsp      out        rsp_valid/rsp_stall   magnitude, out_row, out_column,
//                                             frame_last
//   csr      in         csr_we                csr_index, csr_wdata
//
// A border beat is only accepted and loaded; an interior beat goes on through
// square, prep, the bit-pair square root loop in the datapath and output.
// Synchronous reset sets both sizes to 4096 and the position to row 0,
// column 0; the line buffer RAM is not cleared.
// A result waits in the output register under rsp_stall while the next beat
// is taken; a second finished result holds the controller until it drains.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_stream (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [sem_pkg::PIX_W-1:0]       req_pixel,
   input  logic                            req_frame_start,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [sem_pkg::PIX_W-1:0]       rsp_magnitude,
   output logic [sem_pkg::OUT_POS_W-1:0]   rsp_out_row,
   output logic [sem_pkg::OUT_POS_W-1:0]   rsp_out_column,
   output logic                            rsp_frame_last,
   input  logic                            csr_we,
   input  logic [sem_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sem_pkg::CFG_W-1:0]       csr_wdata
);
   import sem_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   sem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   sem_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_pixel       (req_pixel),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_magnitude   (rsp_magnitude),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_column  (rsp_out_column),
      .rsp_frame_last  (rsp_frame_last)
   );

endmodule

// ===== tb/sv/sobel_edge_magnitude_stream_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude stream testbench
// Streams raster pixel frames through the block under bursty valid and a
// patterned result stall. An in-bench model of the line buffers, the window
// and the position counters predicts each interior result, which is checked
// field by field in order. Sizes are rewritten between phases: small frames,
// clamped values, a mid-frame shrink and a tall frame with an oversize height.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_stream_test;
   import sem_pkg::*;

   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 4000000;
   localparam int RANDOM_ITEMS  = 200;
   localparam int TALL_ROWS     = 40;
   localparam int PRINT_LIMIT   = 100;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             frame_start;
   } pixel_beat_type;

   typedef struct packed {
      logic [PIX_W-1:0]     magnitude;
      logic [OUT_POS_W-1:0] row;
      logic [OUT_POS_W-1:0] column;
      logic                 frame_last;
   } edge_result_type;

   typedef enum {FILL_RANDOM, FILL_BINARY, FILL_FLAT} fill_type;
   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [PIX_W-1:0]     req_pixel = '0;
   logic                 req_frame_start = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [PIX_W-1:0]     rsp_magnitude;
   logic [OUT_POS_W-1:0] rsp_out_row;
   logic [OUT_POS_W-1:0] rsp_out_column;
   logic                 rsp_frame_last;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;

   pixel_beat_type  pending_pixels[$];
   edge_result_type expected_edges[$];

   // model state
   logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
   logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
   int               left_col[3] = '{0, 0, 0};
   int               mid_col[3] = '{0, 0, 0};
   int               row_pos = 0;
   int               col_pos = 0;
   logic [CFG_W-1:0] width_reg = CFG_W'(MAX_WIDTH);
   logic [CFG_W-1:0] height_reg = CFG_W'(MAX_HEIGHT);

   int              error_count = 0;
   int              cycle_count = 0;
   int              burst_left = 0;
   int              gap_left = 0;
   pixel_beat_type  next_beat;
   stall_mode_type  stall_mode = STALL_NONE;
   int              mode_left = 0;
   int              stall_run = 0;
   logic            stall_next;
   edge_result_type got_edge;
   edge_result_type want_edge;

   sobel_edge_magnitude_stream i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel       (req_pixel),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_magnitude   (rsp_magnitude),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_column  (rsp_out_column),
      .rsp_frame_last  (rsp_frame_last),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic int clamp_size(logic [CFG_W-1:0] value, int limit);
      if (value < SIZE_MIN) return int'(SIZE_MIN);
      if (int'(value) > limit) return limit;
      return int'(value);
   endfunction

   // greedy 8-bit root saturates at 255 by itself
   function automatic logic [PIX_W-1:0] floor_root(int energy);
      logic [PIX_W-1:0] root;
      int               trial;
      root = '0;
      for (int k = PIX_W - 1; k >= 0; k--) begin
         trial = int'(root) + (1 << k);
         if (trial * trial <= energy) root[k] = 1'b1;
      end
      return root;
   endfunction

   task automatic advance_sobel_window(input logic [PIX_W-1:0] pix, input logic start);
      int              w;
      int              h;
      int              r;
      int              c;
      int              up;
      int              md;
      int              p;
      int              gx;
      int              gy;
      edge_result_type res;
      w = clamp_size(width_reg, MAX_WIDTH);
      h = clamp_size(height_reg, MAX_HEIGHT);
      if (start) begin
         row_pos = 0;
         col_pos = 0;
      end
      r = row_pos;
      c = col_pos;
      up = int'(upper_mem[c]);
      md = int'(middle_mem[c]);
      p = int'(pix);
      if (r >= 2 && c >= 2 && r < h && c < w) begin
         gx = (up - left_col[0]) + 2 * (md - left_col[1]) + (p - left_col[2]);
         gy = (left_col[0] + 2 * mid_col[0] + up) - (left_col[2] + 2 * mid_col[2] + p);
         res.magnitude = floor_root(gx * gx + gy * gy);
         res.row = OUT_POS_W'(r - 1);
         res.column = OUT_POS_W'(c - 1);
         res.frame_last = (r == h - 1) && (c == w - 1);
         expected_edges.push_back(res);
      end
      upper_mem[c] = PIX_W'(md);
      middle_mem[c] = pix;
      left_col = mid_col;
      mid_col = '{up, md, p};
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endtask

   task automatic report_mismatch(string what);
      if (error_count < PRINT_LIMIT) $display("mismatch: %s", what);
      error_count++;
   endtask

   task automatic check_field(string name, logic [OUT_POS_W-1:0] got,
                              logic [OUT_POS_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d want %0d (row %0d col %0d)",
                                   name, got, want, want_edge.row, want_edge.column));
   endtask

   // driver: bursts with random gaps, prediction on every accepted beat
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) advance_sobel_window(req_pixel, req_frame_start);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_pixels.size() > 0) begin
               next_beat = pending_pixels.pop_front();
               req_pixel <= next_beat.pixel;
               req_frame_start <= next_beat.frame_start;
               req_valid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: in-order compare, then the next stall value
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got_edge = '{rsp_magnitude, rsp_out_row, rsp_out_column, rsp_frame_last};
            if (expected_edges.size() == 0) begin
               report_mismatch($sformatf("unexpected beat row %0d col %0d",
                                         rsp_out_row, rsp_out_column));
            end else begin
               want_edge = expected_edges.pop_front();
               check_field("magnitude", OUT_POS_W'(got_edge.magnitude),
                           OUT_POS_W'(want_edge.magnitude));
               check_field("out_row", got_edge.row, want_edge.row);
               check_field("out_column", got_edge.column, want_edge.column);
               check_field("frame_last", OUT_POS_W'(got_edge.frame_last),
                           OUT_POS_W'(want_edge.frame_last));
            end
         end
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            STALL_NONE:  stall_next = 1'b0;
            STALL_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
            STALL_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
            default:     stall_next = (cycle_count % 3 == 0);
         endcase
         if (stall_run >= 12) stall_next = 1'b0;
         stall_run = stall_next ? stall_run + 1 : 0;
         rsp_stall <= stall_next;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sobel_edge_magnitude_stream_test failed");
         $finish;
      end
   end

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_IMAGE_WIDTH) width_reg = value;
      else height_reg = value;
   endtask

   task automatic set_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
      write_csr(CSR_IMAGE_WIDTH, w);
      write_csr(CSR_IMAGE_HEIGHT, h);
   endtask

   task automatic wait_idle();
      while (pending_pixels.size() != 0 || req_valid || expected_edges.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_run(int count, logic start_first, fill_type fill);
      int             base;
      pixel_beat_type beat;
      base = $urandom_range(0, 252);
      for (int i = 0; i < count; i++) begin
         case (fill)
            FILL_BINARY: beat.pixel = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            FILL_FLAT:   beat.pixel = PIX_W'(base + $urandom_range(0, 3));
            default:     beat.pixel = PIX_W'($urandom_range(0, 255));
         endcase
         beat.frame_start = start_first && (i == 0);
         pending_pixels.push_back(beat);
      end
   endtask

   task automatic queue_rows(int rows, int p0, int p1, int p2, logic start_first);
      for (int r = 0; r < rows; r++) begin
         pending_pixels.push_back('{PIX_W'(p0), start_first && (r == 0)});
         pending_pixels.push_back('{PIX_W'(p1), 1'b0});
         pending_pixels.push_back('{PIX_W'(p2), 1'b0});
      end
   endtask

   initial begin
      int w;
      int h;
      int frames;
      int count;
      int random_items;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed 3x3 frames
      set_size(CFG_W'(3), CFG_W'(3));
      queue_rows(3, 0, 77, 255, 1'b0);                // saturating vertical edge
      queue_run(5, 1'b1, FILL_RANDOM);                // abandoned by a restart
      queue_rows(1, 10, 10, 10, 1'b1);                // small horizontal edge
      queue_rows(1, 255, 0, 255, 1'b0);
      queue_rows(1, 13, 13, 13, 1'b0);

      // sizes below the minimum clamp to 3
      wait_idle();
      set_size(CFG_W'(0), CFG_W'(2));
      queue_run(9, 1'b1, FILL_BINARY);
      queue_run(9, 1'b1, FILL_RANDOM);

      // shrink width and then height in the middle of a frame
      wait_idle();
      set_size(CFG_W'(8), CFG_W'(6));
      queue_run(3 * 8 + 5, 1'b1, FILL_RANDOM);
      wait_idle();
      write_csr(CSR_IMAGE_WIDTH, CFG_W'(4));
      queue_run(5, 1'b0, FILL_RANDOM);
      wait_idle();
      write_csr(CSR_IMAGE_HEIGHT, CFG_W'(3));
      queue_run(16, 1'b0, FILL_RANDOM);

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         wait_idle();
         w = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
         h = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
         set_size(CFG_W'(w), CFG_W'(h));
         w = clamp_size(CFG_W'(w), MAX_WIDTH);
         h = clamp_size(CFG_W'(h), MAX_HEIGHT);
         frames = $urandom_range(1, 3);
         for (int f = 0; f < frames; f++) begin
            count = ($urandom_range(0, 5) == 0) ? $urandom_range(1, w * h - 1) : w * h;
            queue_run(count, 1'b1, fill_type'($urandom_range(0, 2)));
            random_items += count;
         end
      end

      // oversize height clamps to the maximum, so the 40-row frame never wraps
      wait_idle();
      set_size(CFG_W'(3), CFG_W'(8191));
      queue_run(3 * TALL_ROWS, 1'b1, FILL_RANDOM);

      wait_idle();
      if (error_count == 0) begin
         $display("sobel_edge_magnitude_stream_test passed");
      end else begin
         $display("sobel_edge_magnitude_stream_test failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sem_pkg.sv
rtl/sem_ram.sv
rtl/sem_ctrl.sv
rtl/sem_datapath.sv
rtl/sobel_edge_magnitude_stream.sv
tb/sv/sobel_edge_magnitude_stream_test.sv
